FILE: src/p2t_pkg.sv
// Package for the PDG to transport code converter.
// Holds field widths, range limits, the known-code table and divide-by-constant factors.
// No dependencies.
`default_nettype none

package p2t_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 31;

  localparam logic [31:0] IonLow  = 32'd1000000000;
  localparam logic [31:0] IonHigh = 32'd1009999990;

  // Reciprocal multipliers, exact for any 32-bit unsigned dividend
  localparam logic [31:0] Recip10       = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift  = 35;
  localparam logic [31:0] Recip10k      = 32'hD1B7_1759;
  localparam int unsigned Recip10kShift = 45;

  localparam logic [31:0] CodeGamma  = 32'd22;
  localparam logic [31:0] CodePi0    = 32'd111;
  localparam logic [31:0] CodeEtaP   = 32'd331;

  localparam int unsigned NumKnown = 20;
  localparam logic [11:0] KnownCodes [NumKnown] = '{
    12'd11,   12'd12,   12'd13,   12'd14,   12'd22,
    12'd111,  12'd211,  12'd221,  12'd311,  12'd321,
    12'd331,  12'd2112, 12'd2212, 12'd3112, 12'd3122,
    12'd3212, 12'd3222, 12'd3312, 12'd3322, 12'd3334
  };

  function automatic logic is_known(input logic [31:0] mag);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKnown; i++) begin
      if (mag == {20'd0, KnownCodes[i]}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: src/p2t_convert.sv
// Combinational code conversion for one item.
// Depends on p2t_pkg for limits, the known-code table and reciprocal constants.
`default_nettype none

module p2t_convert
  import p2t_pkg::*;
(
  input  logic signed [InWidth-1:0]  pdg_code_i,
  output logic signed [OutWidth-1:0] transport_code_o
);

  logic        neg;
  logic [31:0] mag;
  logic [31:0] ion_diff;
  logic [23:0] ion_ofs;
  logic [55:0] prod10;
  logic [55:0] prod10k;
  logic [19:0] q10;
  logic [9:0]  z;
  logic [23:0] iso_full;
  logic [19:0] a_full;
  logic [3:0]  iso;
  logic [9:0]  a;
  logic [30:0] ion_code;
  logic        std_ok;
  logic        ion_ok;
  logic        self_conj;

  assign neg      = pdg_code_i[InWidth-1];
  assign mag      = neg ? (32'd0 - $unsigned(pdg_code_i)) : $unsigned(pdg_code_i);
  assign ion_diff = mag - IonLow;
  assign ion_ofs  = ion_diff[23:0];

  // ion_ofs = ZZZAAAI, below 1e7
  assign prod10   = {32'd0, ion_ofs} * {24'd0, Recip10};
  assign prod10k  = {32'd0, ion_ofs} * {24'd0, Recip10k};
  assign q10      = prod10[Recip10Shift +: 20];
  assign z        = prod10k[Recip10kShift +: 10];

  assign iso_full = ion_ofs - ({4'd0, q10} * 24'd10);
  assign a_full   = q10 - ({10'd0, z} * 20'd1000);
  assign iso      = iso_full[3:0];
  assign a        = a_full[9:0];
  assign ion_code = ({21'd0, z} * 31'd1000000) + {21'd0, a};

  assign self_conj = neg && (mag == CodeGamma || mag == CodePi0 || mag == CodeEtaP);
  assign std_ok    = (mag <= IonLow) && is_known(mag) && !self_conj;
  assign ion_ok    = !neg && (mag > IonLow) && (mag <= IonHigh) && (iso == 4'd0)
                     && (a != 10'd0) && (z != 10'd0) && (z <= a);

  always_comb begin
    if (std_ok) begin
      transport_code_o = pdg_code_i[OutWidth-1:0];
    end else if (ion_ok) begin
      transport_code_o = ion_code;
    end else begin
      transport_code_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/pdg_to_transport_code.sv
// Top level of the PDG to transport code converter: input register, conversion, result register.
// Depends on p2t_pkg and p2t_convert.
`default_nettype none

// Converts one signed PDG code per item into the transport code (Z*1000000+A for ions, the code
// itself for supported particles, 0 otherwise). Throughput is one item per clock unless the
// result side stalls; items pass the input register, the conversion pass and the result register.
// in_stall_o rises only when both registers hold items and the result side stalls.

module pdg_to_transport_code
  import p2t_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [InWidth-1:0]  pdg_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OutWidth-1:0] transport_code_o
);

  logic                       in_vld_q, in_vld_d;
  logic signed [InWidth-1:0]  code_q;
  logic                       out_vld_q, out_vld_d;
  logic signed [OutWidth-1:0] res_q;
  logic signed [OutWidth-1:0] res_d;
  logic                       advance;
  logic                       in_acc;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  p2t_convert u_convert (
    .pdg_code_i       (code_q),
    .transport_code_o (res_d)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= pdg_code_i;
    end
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign transport_code_o = res_q;

endmodule

`default_nettype wire

FILE: verif/pdg_to_transport_code_tb.sv
`timescale 1ns / 1ps
// Testbench for pdg_to_transport_code: drives directed and random PDG codes under idle and stall
// patterns and checks every transport code against a predictor held in a scoreboard class.
// Depends on p2t_pkg and the pdg_to_transport_code RTL.

module pdg_to_transport_code_tb;
  import p2t_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [31:0] ION_FLOOR = 32'd1000000000;
  localparam logic [31:0] ION_CEIL  = 32'd1009999990;
  localparam logic [31:0] PHOTON    = 32'd22;
  localparam logic [31:0] PION0     = 32'd111;
  localparam logic [31:0] ETA_PRIME = 32'd331;

  localparam logic [31:0] PARTICLE_CODES [20] = '{
    32'd11,   32'd12,   32'd13,   32'd14,   32'd22,
    32'd111,  32'd211,  32'd221,  32'd311,  32'd321,
    32'd331,  32'd2112, 32'd2212, 32'd3112, 32'd3122,
    32'd3212, 32'd3222, 32'd3312, 32'd3322, 32'd3334
  };

  class code_scoreboard;
    logic signed [OutWidth-1:0] pending_codes[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function logic signed [OutWidth-1:0] convert_code(logic [31:0] raw);
      logic        neg;
      logic        hit;
      logic [31:0] mag;
      logic [31:0] iso;
      logic [31:0] mass;
      logic [31:0] charge;
      logic [31:0] ion;
      neg = raw[31];
      mag = neg ? -raw : raw;
      if (mag <= ION_FLOOR) begin
        hit = 1'b0;
        foreach (PARTICLE_CODES[i]) begin
          if (PARTICLE_CODES[i] == mag) hit = 1'b1;
        end
        if (!hit) return '0;
        if (neg && (mag == PHOTON || mag == PION0 || mag == ETA_PRIME)) return '0;
        return neg ? -mag[OutWidth-1:0] : mag[OutWidth-1:0];
      end
      if (mag <= ION_CEIL && !neg) begin
        iso    = mag % 10;
        mass   = (mag / 10) % 1000;
        charge = (mag / 10000) % 1000;
        if (iso != 0 || mass == 0 || charge == 0 || charge > mass) return '0;
        ion = charge * 32'd1000000 + mass;
        return ion[OutWidth-1:0];
      end
      return '0;
    endfunction

    function void note_code(logic [31:0] raw);
      pending_codes.push_back(convert_code(raw));
    endfunction

    function void check_code(logic signed [OutWidth-1:0] got);
      logic signed [OutWidth-1:0] want;
      if (pending_codes.size() == 0) begin
        $error("transport_code: no item expected, got %0d", got);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      if (got !== want) begin
        $error("transport_code: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [InWidth-1:0]  pdg_code_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [OutWidth-1:0] transport_code_o;

  code_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  int unsigned    hold_left;
  bit             hold_request;
  int unsigned    cycles;

  pdg_to_transport_code u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pdg_code_i       (pdg_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .transport_code_o (transport_code_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_code(transport_code_o);
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_code(input logic [31:0] code);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      pdg_code_i <= $urandom();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pdg_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_code(code);
  endtask

  function automatic logic [31:0] random_code();
    int unsigned pick;
    logic [31:0] code;
    logic [31:0] charge;
    logic [31:0] mass;
    pick = $urandom_range(99);
    if (pick < 25) begin
      code = PARTICLE_CODES[$urandom_range(19)];
    end else if (pick < 60) begin
      mass   = $urandom_range(999, 1);
      charge = $urandom_range(mass, 1);
      return ION_FLOOR + charge * 10000 + mass * 10;
    end else if (pick < 72) begin
      code = ION_FLOOR + $urandom_range(999) * 10000 + $urandom_range(999) * 10
             + $urandom_range(9);
    end else if (pick < 80) begin
      code = $urandom_range(1) ? ION_FLOOR + $urandom_range(3) - 1
                               : ION_CEIL + $urandom_range(20) - 10;
    end else if (pick < 88) begin
      code = $urandom_range(4000);
    end else begin
      return $urandom();
    end
    return $urandom_range(1) ? -code : code;
  endfunction

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_code(random_code());
  endtask

  initial begin
    logic [31:0] directed [25] = '{
      32'd0, 32'd11, -32'd11, 32'd3334, -32'd3334, PHOTON, -PHOTON, -PION0, -ETA_PRIME,
      ETA_PRIME, 32'd2112, 32'd3335, ION_FLOOR, -ION_FLOOR, 32'd1000010010, 32'd1000010011,
      32'd1000020010, 32'd1000010000, 32'd1000000010, ION_CEIL, ION_CEIL + 1,
      -32'd1000010010, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1009990990
    };
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pdg_code_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_code(directed[i]);

    run_phase(0, 0, 200);
    run_phase(53, 0, 200);
    run_phase(0, 53, 200);
    run_phase(9, 9, 200);

    // long hold-off on the result side while items keep coming
    stall_pct = 0;
    send_idle_pct = 0;
    hold_request = 1'b1;
    repeat (40) send_code(random_code());
    run_phase(0, 0, 10);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
